### hw/rtl/sha512_pkg.sv
// sha512_pkg: shared types, round constants, initial hash values and sigma functions
// used by sha512_round and sha512_hash_engine; no dependencies
package sha512_pkg;

    typedef logic [63:0] word_t;
    typedef logic [7:0][63:0] hash_vec_t;

    localparam int unsigned NumRounds = 80;

    localparam logic [63:0] K_TAB [NumRounds] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h6f1c0e5b6c823b93,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [63:0] IV_TAB [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic word_t ror64(input word_t x, input int unsigned n);
        ror64 = (x >> n) | (x << (64 - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        sig0 = ror64(x, 1) ^ ror64(x, 8) ^ (x >> 7);
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = ror64(x, 19) ^ ror64(x, 61) ^ (x >> 6);
    endfunction

endpackage

### hw/rtl/sha512_round.sv
// sha512_round: one compression round on the eight working words
// depends on sha512_pkg
module sha512_round
    import sha512_pkg::*;
(
    input  hash_vec_t v_in,
    input  word_t     k_in,
    input  word_t     w_in,
    output hash_vec_t v_out
);
    word_t t1;
    word_t t2;

    always_comb begin
        t1 = v_in[7] + (ror64(v_in[4], 14) ^ ror64(v_in[4], 18) ^ ror64(v_in[4], 41))
           + ((v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6])) + k_in + w_in;
        t2 = (ror64(v_in[0], 28) ^ ror64(v_in[0], 34) ^ ror64(v_in[0], 39))
           + ((v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]));
        v_out[7] = v_in[6];
        v_out[6] = v_in[5];
        v_out[5] = v_in[4];
        v_out[4] = v_in[3] + t1;
        v_out[3] = v_in[2];
        v_out[2] = v_in[1];
        v_out[1] = v_in[0];
        v_out[0] = t1 + t2;
    end
endmodule

### hw/rtl/sha512_hash_engine.sv
// sha512_hash_engine: streaming sha-512, one input beat per message word, eight digest beats
// a beat that fills no block and is not the last leaves the engine idle; a full block runs 80 rounds
// last beat: padding writes plus one or two compressions, then the 8 digest beats
// s_ready is low while a block runs through the one-round-per-cycle unit; no new beat until idle
// reset: aresetn synchronous active low; chain reads as the initial hash, counts cleared
// depends on sha512_pkg and sha512_round
module sha512_hash_engine
    import sha512_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_word,
    input  logic [3:0]  s_valid_bytes,
    input  logic        s_last_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_COMP  = 5'b00010,
        ST_WB_RD = 5'b00100,
        ST_WB_OP = 5'b01000,
        ST_PAD   = 5'b10000
    } state_t;

    // first round runs at this count, chain loads in counts 1..8
    localparam logic [6:0] RoundBase = 7'd10;
    localparam logic [6:0] SchedBase = 7'd9;
    localparam logic [6:0] BlkRdBase = 7'd8;
    localparam logic [6:0] LastCnt   = 7'd89;

    state_t       state_reg, state_next;
    logic [6:0]   cnt_reg;
    logic [2:0]   idx_reg;
    logic [6:0]   fill_reg;
    logic [63:0]  acc_reg;
    logic [127:0] len_reg;
    logic         iv_flag_reg;
    logic         last_pend_reg;
    logic         final_reg;
    logic         pass1_reg;
    logic         first_reg;
    logic [3:0]   pw_reg;

    // block buffer and chain memories, registered read data
    logic [63:0]  blk_mem [16];
    logic [63:0]  chain_mem [8];
    logic         blk_we;
    logic [3:0]   blk_waddr;
    logic [63:0]  blk_wdata;
    logic [3:0]   blk_raddr;
    logic [63:0]  blk_rdata_reg;
    logic         chain_we;
    logic         chain_re;
    logic [2:0]   chain_raddr;
    logic [2:0]   chain_rd_idx_reg;
    logic [63:0]  chain_rdata_reg;
    logic [63:0]  chain_eff;

    hash_vec_t    v_reg;
    hash_vec_t    v_round;
    logic [63:0]  win_reg [16];
    logic [63:0]  wcur_reg;
    logic [63:0]  wnew;
    logic [6:0]   sched_j;
    logic [6:0]   round_j;

    logic         m_valid_reg;
    logic [63:0]  m_data_reg;
    logic [2:0]   m_idx_reg;
    logic         m_last_reg;

    // input merge
    logic [3:0]   nb;
    logic [2:0]   off;
    logic [63:0]  keep_mask;
    logic [127:0] win128;
    logic [3:0]   total;
    logic         word_done;
    logic         blk_done;
    logic [6:0]   fill_sum;
    logic [63:0]  pad_word;
    logic [63:0]  wb_sum;
    logic         accept;
    logic         out_free;
    logic         out_load;

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_digest_word = m_data_reg;
    assign m_word_index  = m_idx_reg;
    assign m_last_word   = m_last_reg;
    assign out_free      = !m_valid_reg || m_ready;
    // a digest beat moves into the output register
    assign out_load      = (state_reg == ST_WB_OP) && final_reg && out_free;

    always_comb begin
        nb        = (s_valid_bytes > 4'd8) ? 4'd8 : s_valid_bytes;
        off       = fill_reg[2:0];
        keep_mask = ~(64'hffff_ffff_ffff_ffff >> {nb, 3'b000});
        win128    = {acc_reg, 64'h0} | ({s_data_word & keep_mask, 64'h0} >> {off, 3'b000});
        total     = {1'b0, off} + nb;
        word_done = total[3];
        blk_done  = word_done && (fill_reg[6:3] == 4'd15);
        fill_sum  = fill_reg + {3'b000, nb};
        pad_word  = acc_reg | ({PAD_BYTE, 56'h0} >> {off, 3'b000});
    end

    // chain reads as the initial hash until the first block writes back
    assign chain_eff = iv_flag_reg ? IV_TAB[chain_rd_idx_reg] : chain_rdata_reg;
    assign wb_sum    = chain_eff + v_reg[idx_reg];

    // schedule: window holds w[j-16..j-1]
    assign sched_j = cnt_reg - SchedBase;
    assign round_j = cnt_reg - RoundBase;
    assign wnew    = sig1(win_reg[14]) + win_reg[9] + sig0(win_reg[1]) + win_reg[0];

    sha512_round u_round (
        .v_in  (v_reg),
        .k_in  (K_TAB[round_j]),
        .w_in  (wcur_reg),
        .v_out (v_round)
    );

    // memory port control
    always_comb begin
        blk_we    = 1'b0;
        blk_waddr = fill_reg[6:3];
        blk_wdata = win128[127:64];
        blk_raddr = 4'(cnt_reg - BlkRdBase);
        chain_re    = 1'b0;
        chain_raddr = idx_reg;
        chain_we    = 1'b0;
        if (accept && word_done) begin
            blk_we = 1'b1;
        end
        if (state_reg == ST_PAD) begin
            blk_we    = 1'b1;
            blk_waddr = pw_reg;
            priority if (first_reg) begin
                blk_wdata = pad_word;
            end else if (!pass1_reg && pw_reg == 4'd14) begin
                blk_wdata = len_reg[127:64];
            end else if (!pass1_reg && pw_reg == 4'd15) begin
                blk_wdata = len_reg[63:0];
            end else begin
                blk_wdata = 64'h0;
            end
        end
        if (state_reg == ST_COMP && cnt_reg < 7'd8) begin
            chain_re    = 1'b1;
            chain_raddr = cnt_reg[2:0];
        end
        if (state_reg == ST_WB_RD) begin
            chain_re = 1'b1;
        end
        if (state_reg == ST_WB_OP && !final_reg) begin
            chain_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (blk_we) begin
            blk_mem[blk_waddr] <= blk_wdata;
        end
        blk_rdata_reg <= blk_mem[blk_raddr];
        if (chain_we) begin
            chain_mem[idx_reg] <= wb_sum;
        end
        if (chain_re) begin
            chain_rdata_reg  <= chain_mem[chain_raddr];
            chain_rd_idx_reg <= chain_raddr;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_COMP) begin
            if (cnt_reg >= 7'd1 && cnt_reg <= 7'd8) begin
                v_reg[chain_rd_idx_reg] <= chain_eff;
            end
            if (cnt_reg >= SchedBase && cnt_reg < LastCnt) begin
                for (int i = 0; i < 15; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                if (sched_j < 7'd16) begin
                    wcur_reg    <= blk_rdata_reg;
                    win_reg[15] <= blk_rdata_reg;
                end else begin
                    wcur_reg    <= wnew;
                    win_reg[15] <= wnew;
                end
            end
            if (cnt_reg >= RoundBase) begin
                v_reg <= v_round;
            end
        end
        if (out_load) begin
            m_data_reg <= wb_sum;
            m_idx_reg  <= idx_reg;
            m_last_reg <= (idx_reg == 3'd7);
        end
    end

    // control
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    priority if (blk_done) begin
                        state_next = ST_COMP;
                    end else if (s_last_of_message) begin
                        state_next = ST_PAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_COMP: begin
                if (cnt_reg == LastCnt) begin
                    state_next = ST_WB_RD;
                end
            end
            ST_WB_RD: state_next = ST_WB_OP;
            ST_WB_OP: begin
                if (!final_reg || out_free) begin
                    priority if (idx_reg != 3'd7) begin
                        state_next = ST_WB_RD;
                    end else if (final_reg) begin
                        state_next = ST_IDLE;
                    end else if (pass1_reg || last_pend_reg) begin
                        state_next = ST_PAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                if (pw_reg == 4'd15) begin
                    state_next = ST_COMP;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            fill_reg      <= '0;
            acc_reg       <= '0;
            len_reg       <= '0;
            iv_flag_reg   <= 1'b1;
            last_pend_reg <= 1'b0;
            final_reg     <= 1'b0;
            pass1_reg     <= 1'b0;
            first_reg     <= 1'b0;
            pw_reg        <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            // output register: a new beat wins over the drain of the old one
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        fill_reg      <= fill_sum;
                        acc_reg       <= word_done ? win128[63:0] : win128[127:64];
                        len_reg       <= len_reg + {121'h0, nb, 3'b000};
                        last_pend_reg <= s_last_of_message;
                        cnt_reg       <= '0;
                        final_reg     <= 1'b0;
                        // padding setup when no block completes first
                        pw_reg    <= fill_sum[6:3];
                        first_reg <= 1'b1;
                        pass1_reg <= (fill_sum >= 7'd112);
                    end
                end
                ST_COMP: begin
                    cnt_reg <= cnt_reg + 7'd1;
                    idx_reg <= '0;
                end
                ST_WB_RD: ;
                ST_WB_OP: begin
                    if (final_reg) begin
                        if (out_free) begin
                            idx_reg <= idx_reg + 3'd1;
                            if (idx_reg == 3'd7) begin
                                // back to the empty-message state
                                iv_flag_reg   <= 1'b1;
                                fill_reg      <= '0;
                                acc_reg       <= '0;
                                len_reg       <= '0;
                                last_pend_reg <= 1'b0;
                                final_reg     <= 1'b0;
                            end
                        end
                    end else begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7) begin
                            iv_flag_reg <= 1'b0;
                            priority if (pass1_reg && !first_reg) begin
                                // second padding block: zeros then length
                                pass1_reg <= 1'b0;
                                pw_reg    <= '0;
                            end else begin
                                // leftover bytes of the last beat stay in acc
                                pw_reg    <= fill_reg[6:3];
                                first_reg <= 1'b1;
                                pass1_reg <= (fill_reg >= 7'd112);
                            end
                        end
                    end
                end
                ST_PAD: begin
                    first_reg <= 1'b0;
                    pw_reg    <= pw_reg + 4'd1;
                    cnt_reg   <= '0;
                    if (pw_reg == 4'd15) begin
                        final_reg     <= !pass1_reg;
                        last_pend_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
